/* src/fts_pkg.sv */
// shared types, constants and byte helpers for the fuzzy text match scorer
// no dependencies; imported by every module of the block
package fts_pkg;

  localparam int SCORE_W = 19;
  localparam int SCORE_MIN = -262144;
  localparam int SUBSTR_BASE = 2200;
  localparam logic [11:0] PTS_MATCH = 12'd40;
  localparam logic [11:0] PTS_STREAK = 12'd25;
  localparam logic [11:0] PTS_WORD = 12'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_QUERY_0  = 3'd0,
    REG_QUERY_1  = 3'd1,
    REG_QUERY_2  = 3'd2,
    REG_QUERY_3  = 3'd3,
    REG_QLEN     = 3'd4,
    REG_CASE     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MK_NONE   = 2'd0,
    MK_SUBSTR = 2'd1,
    MK_SUBSEQ = 2'd2,
    MK_EMPTY  = 2'd3
  } match_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [1:0]                match_kind;
    logic                      length_saturated;
  } out_item_t;

  typedef struct packed {
    logic [255:0] query;
    logic [5:0]   query_length;
    logic         case_exact;
  } cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
    logic [7:0] r;
    r = b;
    if (!cs && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_UNDERSCORE) || (b == CH_DASH) || (b == CH_SLASH);
  endfunction

endpackage

/* src/fts_cfg.sv */
// register file behind the apb-style configuration port
// depends on fts_pkg for the register indexes and the config struct
module fts_cfg
  import fts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [3:0][63:0] query_r;
  logic [5:0]       qlen_r;
  logic             case_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
      qlen_r  <= '0;
      case_r  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_QUERY_0: query_r[0] <= pwdata;
        REG_QUERY_1: query_r[1] <= pwdata;
        REG_QUERY_2: query_r[2] <= pwdata;
        REG_QUERY_3: query_r[3] <= pwdata;
        REG_QLEN:    qlen_r     <= pwdata[5:0];
        REG_CASE:    case_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUERY_0: prdata = query_r[0];
      REG_QUERY_1: prdata = query_r[1];
      REG_QUERY_2: prdata = query_r[2];
      REG_QUERY_3: prdata = query_r[3];
      REG_QLEN:    prdata = {58'd0, qlen_r};
      REG_CASE:    prdata = {63'd0, case_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.query        = query_r;
  assign cfg.query_length = qlen_r;
  assign cfg.case_exact   = case_r;

endmodule

/* src/fts_core.sv */
// per-text match state: recent byte window, substring compare, greedy subsequence
// and the final score; depends on fts_pkg
module fts_core
  import fts_pkg::*;
#(
  parameter int QUERY_MAX   = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  localparam int QL_W = $clog2(QUERY_MAX + 1);
  localparam int QI_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int SW   = LENGTH_BITS + 5;
  localparam int ZW   = (SW > SCORE_W) ? SW : SCORE_W;
  localparam logic signed [ZW-1:0] SCORE_FLOOR = ZW'(SCORE_MIN);
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

  logic [7:0]             win_r   [QUERY_MAX];
  logic [7:0]             win_sh  [QUERY_MAX];
  logic [7:0]             qf      [QUERY_MAX];
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [LENGTH_BITS-1:0] start_r, start_nxt;
  logic                   hit_r, hit_nxt;
  logic [QL_W-1:0]        mc_r, mc_nxt;
  logic                   streak_r, streak_nxt;
  logic [11:0]            pts_r, pts_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [QL_W-1:0]        qlen;
  logic [7:0]             byte_f;
  logic                   pos_sat;
  logic                   eq;
  logic                   word_start;
  logic [11:0]            pts_add;

  logic signed [SW-1:0]   start_s, pos_s, sc;
  logic signed [ZW-1:0]   sc_ext;
  match_kind_t            kind;

  always_comb begin
    qlen = (cfg.query_length > 6'(QUERY_MAX)) ? QL_W'(QUERY_MAX) : QL_W'(cfg.query_length);
    for (int k = 0; k < QUERY_MAX; k++) begin
      qf[k] = fold_byte(cfg.query[8*k +: 8], cfg.case_exact);
    end
  end

  // window compare against the query, newest byte aligned to the last query byte
  always_comb begin
    logic [QL_W-1:0] idx;
    byte_f  = fold_byte(item.text_byte, cfg.case_exact);
    pos_sat = (pos_r == POS_MAX);
    pos_inc = pos_sat ? pos_r : pos_r + 1'b1;
    win_sh[0] = byte_f;
    for (int j = 1; j < QUERY_MAX; j++) begin
      win_sh[j] = win_r[j-1];
    end
    eq = 1'b1;
    for (int j = 0; j < QUERY_MAX; j++) begin
      idx = qlen - QL_W'(j) - 1'b1;
      if (QL_W'(j) < qlen && win_sh[j] != qf[idx[QI_W-1:0]]) begin
        eq = 1'b0;
      end
    end
  end

  always_comb begin
    word_start = (pos_r == '0) || is_separator(prev_r);
    pts_add    = PTS_MATCH + (streak_r ? PTS_STREAK : 12'd0) + (word_start ? PTS_WORD : 12'd0);

    pos_nxt    = pos_r;
    start_nxt  = start_r;
    hit_nxt    = hit_r;
    mc_nxt     = mc_r;
    streak_nxt = streak_r;
    pts_nxt    = pts_r;
    prev_nxt   = prev_r;
    ovf_nxt    = ovf_r;

    if (item.byte_present) begin
      pos_nxt  = pos_inc;
      ovf_nxt  = ovf_r | pos_sat;
      prev_nxt = byte_f;
      if (qlen != '0 && !hit_r && pos_inc >= LENGTH_BITS'(qlen) && eq) begin
        hit_nxt   = 1'b1;
        start_nxt = pos_inc - LENGTH_BITS'(qlen);
      end
      if (mc_r < qlen) begin
        if (byte_f == qf[mc_r[QI_W-1:0]]) begin
          pts_nxt    = pts_r + pts_add;
          streak_nxt = 1'b1;
          mc_nxt     = mc_r + 1'b1;
        end else begin
          streak_nxt = 1'b0;
        end
      end
    end
  end

  // score from the state as it stands after this item
  always_comb begin
    start_s = signed'(SW'(start_nxt));
    pos_s   = signed'(SW'(pos_nxt));
    if (qlen == '0) begin
      sc   = '0;
      kind = MK_EMPTY;
    end else if (hit_nxt) begin
      sc   = SW'(SUBSTR_BASE) - (start_s <<< 1) - start_s - pos_s;
      kind = MK_SUBSTR;
    end else if (mc_nxt >= qlen) begin
      sc   = signed'(SW'(pts_nxt)) - pos_s;
      kind = MK_SUBSEQ;
    end else begin
      sc   = -SW'(1);
      kind = MK_NONE;
    end
    sc_ext = ZW'(sc);
    if (sc_ext < SCORE_FLOOR) begin
      sc_ext = SCORE_FLOOR;
    end
    res.score            = sc_ext[SCORE_W-1:0];
    res.match_kind       = kind;
    res.length_saturated = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (go && item.byte_present) begin
      for (int j = 0; j < QUERY_MAX; j++) begin
        win_r[j] <= win_sh[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.end_of_text)) begin
      pos_r    <= '0;
      start_r  <= '0;
      hit_r    <= 1'b0;
      mc_r     <= '0;
      streak_r <= 1'b0;
      pts_r    <= '0;
      prev_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (go) begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      hit_r    <= hit_nxt;
      mc_r     <= mc_nxt;
      streak_r <= streak_nxt;
      pts_r    <= pts_nxt;
      prev_r   <= prev_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

/* src/fuzzy_text_match_scorer.sv */
// Fuzzy text match scorer. A text streams in one byte per item and the score
// comes out as one item after the item flagged end_of_text. One item is taken
// every cycle unless the input is stalled; each item sits in the input register,
// where the 32-byte window compare and the greedy subsequence step run, and
// the result of a closing item is written to the output register, which
// raises out_valid. While an earlier result is stalled at the output, a closing
// item waits in the input register and stalls the input.
// Configuration sits behind an apb-style port with 64-bit registers at 8*i.
// Depends on fts_pkg, fts_cfg and fts_core.
module fuzzy_text_match_scorer
  import fts_pkg::*;
#(
  parameter int QUERY_MAX   = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_v_r;
  out_item_t out_item_r;
  logic      out_v_r;
  out_item_t res;
  logic      go;
  logic      in_take;

  fts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fts_core #(
    .QUERY_MAX   (QUERY_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // an item that closes a text needs room in the output register
  assign go       = in_v_r && (!in_item_r.end_of_text || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go && in_item_r.end_of_text) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_item_r.end_of_text) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(go && in_item_r.end_of_text))
    else $error("result raised without a closing item");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !go |=> in_v_r && $stable(in_item_r))
    else $error("held input item lost or changed");

  a_empty_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_item_r.match_kind == MK_EMPTY |-> out_item_r.score == '0)
    else $error("empty query with non-zero score");

  a_none_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_item_r.match_kind == MK_NONE |-> out_item_r.score == '1)
    else $error("no match without score of minus one");

endmodule

/* verif/fuzzy_text_match_scorer_tb.sv */
// self-checking testbench for fuzzy_text_match_scorer: streams texts, predicts scores
// depends on fts_pkg and the fuzzy_text_match_scorer top level
module fuzzy_text_match_scorer_tb;
  import fts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  fuzzy_text_match_scorer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [63:0] query_reg [4];
  logic [5:0]  query_len_reg;
  logic        exact_case;

  // predictor copy of the per-text state
  logic [7:0]  window_bytes [32];
  logic [15:0] text_len;
  logic        found_substr;
  logic [15:0] substr_pos;
  logic [5:0]  greedy_count;
  logic        greedy_streak;
  logic [11:0] greedy_points;
  logic [7:0]  last_byte;
  logic        len_clamped;

  in_item_t  text_stream [$];
  out_item_t pending_scores [$];
  int items_queued = 0;
  int items_taken = 0;
  int scored_items = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_armed = 1'b0;
  logic hold_active = 1'b0;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (!exact_case && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic [7:0] query_raw(input int k);
    return query_reg[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void clear_text_state();
    for (int i = 0; i < 32; i++) window_bytes[i] = 8'h00;
    text_len = '0;
    found_substr = 1'b0;
    substr_pos = '0;
    greedy_count = '0;
    greedy_streak = 1'b0;
    greedy_points = '0;
    last_byte = 8'h00;
    len_clamped = 1'b0;
  endfunction

  function automatic void score_text_byte(input in_item_t it);
    int qlen;
    int score;
    logic [7:0] b;
    logic word_start;
    logic same;
    match_kind_t kind;
    out_item_t res;
    qlen = (query_len_reg > 32) ? 32 : int'(query_len_reg);
    if (it.byte_present) begin
      b = fold_case(it.text_byte);
      word_start = (text_len == 0) || (last_byte == CH_SPACE) || (last_byte == CH_UNDERSCORE) ||
                   (last_byte == CH_DASH) || (last_byte == CH_SLASH);
      if (text_len == 16'hFFFF) begin
        len_clamped = 1'b1;
      end else begin
        text_len = text_len + 16'd1;
      end
      for (int i = 31; i > 0; i--) window_bytes[i] = window_bytes[i - 1];
      window_bytes[0] = b;
      if (qlen > 0 && !found_substr && text_len >= qlen) begin
        same = 1'b1;
        for (int k = 0; k < qlen; k++) begin
          if (window_bytes[qlen - 1 - k] != fold_case(query_raw(k))) same = 1'b0;
        end
        if (same) begin
          found_substr = 1'b1;
          substr_pos = text_len - 16'(qlen);
        end
      end
      if (greedy_count < qlen) begin
        if (b == fold_case(query_raw(greedy_count))) begin
          greedy_points = greedy_points + PTS_MATCH;
          if (greedy_streak) greedy_points = greedy_points + PTS_STREAK;
          if (word_start) greedy_points = greedy_points + PTS_WORD;
          greedy_streak = 1'b1;
          greedy_count = greedy_count + 6'd1;
        end else begin
          greedy_streak = 1'b0;
        end
      end
      last_byte = b;
    end
    if (it.end_of_text) begin
      if (qlen == 0) begin
        score = 0;
        kind = MK_EMPTY;
      end else if (found_substr) begin
        score = SUBSTR_BASE - 3 * int'(substr_pos) - int'(text_len);
        kind = MK_SUBSTR;
      end else if (greedy_count >= qlen) begin
        score = int'(greedy_points) - int'(text_len);
        kind = MK_SUBSEQ;
      end else begin
        score = -1;
        kind = MK_NONE;
      end
      if (score < SCORE_MIN) score = SCORE_MIN;
      res.score = score[SCORE_W-1:0];
      res.match_kind = kind;
      res.length_saturated = len_clamped;
      pending_scores.insert(pending_scores.size(), res);
      clear_text_state();
    end
  endfunction

  // text byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        score_text_byte(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (text_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= text_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_armed);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  // score checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected score item: score %0d kind %0d saturated %0b",
                   $signed(out_data.score), out_data.match_kind, out_data.length_saturated);
        end
      end else begin
        want = pending_scores.pop_front();
        if (out_data.score !== want.score || out_data.match_kind !== want.match_kind ||
            out_data.length_saturated !== want.length_saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("score mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                     $signed(want.score), want.match_kind, want.length_saturated,
                     $signed(out_data.score), out_data.match_kind, out_data.length_saturated);
          end
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic present, input logic last);
    text_stream.insert(text_stream.size(),
                       in_item_t'{text_byte: b, byte_present: present, end_of_text: last});
    items_queued++;
    if (present || last) scored_items++;
  endtask

  task automatic push_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, close && (i == s.len() - 1));
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued) @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_QLEN: begin
        query_len_reg = value[5:0];
      end
      REG_CASE: begin
        exact_case = value[0];
      end
      default: begin
        query_reg[int'(idx)] = value;
      end
    endcase
  endtask

  task automatic load_query(input string q, input logic [5:0] len, input logic cs);
    logic [63:0] words [4];
    for (int k = 0; k < 32; k++) begin
      words[k / 8][(k % 8) * 8 +: 8] = (k < q.len()) ? q[k] : 8'($urandom_range(255));
    end
    for (int r = 0; r < 4; r++) cfg_write(reg_idx_t'(r), words[r]);
    cfg_write(REG_QLEN, 64'(len));
    cfg_write(REG_CASE, 64'(cs));
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'h61 + 8'($urandom_range(5));
    if (r < 58) return 8'h41 + 8'($urandom_range(5));
    if (r < 70) begin
      case ($urandom_range(3))
        0: return CH_SPACE;
        1: return CH_UNDERSCORE;
        2: return CH_DASH;
        default: return CH_SLASH;
      endcase
    end
    if (r < 75) begin
      case ($urandom_range(3))
        0: return 8'h40;
        1: return CH_UPPER_A;
        2: return CH_UPPER_Z;
        default: return 8'h5B;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic letter;
    letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= 8'h61 && c <= 8'h7A);
    if (letter && $urandom_range(6) == 0) return c ^ CASE_OFFSET;
    return c;
  endfunction

  task automatic random_setting();
    logic [63:0] word;
    logic [5:0] len;
    int pick;
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(6) == 0) begin
        word = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) word[k * 8 +: 8] = pick_char();
      end
      cfg_write(reg_idx_t'(r), word);
    end
    pick = $urandom_range(19);
    if (pick < 2) len = 6'd0;
    else if (pick < 5) len = 6'd1;
    else if (pick < 8) len = 6'd32;
    else if (pick < 10) len = 6'($urandom_range(63, 33));
    else len = 6'($urandom_range(8, 2));
    cfg_write(REG_QLEN, 64'(len));
    cfg_write(REG_CASE, 64'($urandom_range(1)));
  endtask

  // mostly texts built around the query, some pure noise
  task automatic push_random_text(input bit close);
    logic [7:0] txt [$];
    int qlen;
    int style;
    int n;
    bit on_byte;
    qlen = (query_len_reg > 32) ? 32 : int'(query_len_reg);
    style = $urandom_range(9);
    on_byte = ($urandom_range(4) != 0);
    if (style <= 3) begin
      n = $urandom_range(8);
      repeat (n) txt.insert(txt.size(), pick_char());
      for (int k = 0; k < qlen; k++) txt.insert(txt.size(), vary_case(query_raw(k)));
      n = $urandom_range(6);
      repeat (n) txt.insert(txt.size(), pick_char());
    end else if (style <= 6) begin
      for (int k = 0; k < qlen; k++) begin
        n = $urandom_range(2);
        repeat (n) txt.insert(txt.size(), pick_char());
        if ($urandom_range(19) != 0) txt.insert(txt.size(), vary_case(query_raw(k)));
      end
    end else if (style <= 8) begin
      n = $urandom_range(20);
      repeat (n) txt.insert(txt.size(), pick_char());
    end
    foreach (txt[i]) begin
      if ($urandom_range(19) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(txt[i], 1'b1, close && on_byte && (i == txt.size() - 1));
    end
    if (close && (!on_byte || txt.size() == 0)) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int start;
    int guard;
    int idle_mix [4];
    int stall_mix [4];
    idle_mix = '{0, 50, 0, 23};
    stall_mix = '{0, 0, 50, 23};
    for (int r = 0; r < 4; r++) query_reg[r] = '0;
    query_len_reg = '0;
    exact_case = 1'b0;
    clear_text_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty query straight after reset
    push_string("ab", 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    load_query("Ab", 6'd2, 1'b0);
    push_string("xaB", 1'b1);
    push_string("a_xb", 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_string("zz", 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // all-ones query, length above the maximum
    for (int r = 0; r < 4; r++) cfg_write(reg_idx_t'(r), 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_QLEN, 64'd63);
    cfg_write(REG_CASE, 64'd1);
    repeat (32) push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    load_query("AB", 6'd2, 1'b1);
    push_string("ab", 1'b1);
    push_string("A-B", 1'b1);
    wait_idle();

    // shorter query mid-text, greedy count already past it
    load_query("abc", 6'd3, 1'b0);
    push_string("ab", 1'b0);
    wait_idle();
    cfg_write(REG_QLEN, 64'd1);
    push_string("x", 1'b1);
    wait_idle();

    // receiver holds off while short texts keep coming
    load_query("ab", 6'd2, 1'b0);
    hold_armed = 1'b1;
    for (int i = 0; i < 80; i++) push_string((i % 2) ? "xab" : "ab", 1'b1);
    wait_idle();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_mix[m];
      stall_pct = stall_mix[m];
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        random_setting();
        start = scored_items;
        while (scored_items - start < 100) push_random_text(1'b1);
        push_random_text((m == 3 && s == 2) || $urandom_range(2) != 0);
      end
    end

    while (items_taken != items_queued) @(posedge clk);
    guard = 0;
    while (pending_scores.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_scores.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("fuzzy_text_match_scorer verification clean");
    end else begin
      $display("fuzzy_text_match_scorer verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("fuzzy_text_match_scorer verification failed");
    $finish;
  end

endmodule
